/* src/drt_pkg.sv */
// shared types and codes for the device record table
package drt_pkg;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_RM_ID   = 2'd1,
    CMD_RM_ADDR = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [7:0]  dev_type;
    logic [7:0]  dev_id;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [31:0] net_address;
  } rec_t;

  localparam int RecW = $bits(rec_t);

  typedef struct packed {
    cmd_t        command;
    rec_t        rec;
    logic [5:0]  entry_index;
  } in_word_t;

  typedef struct packed {
    logic        done_ok;
    logic [6:0]  entry_count;
    rec_t        rec;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_READ,
    ST_RWAIT,
    ST_SCAN,
    ST_HIT,
    ST_MOVE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic add_exec;
    logic rd_issue;
    logic rd_capture;
    logic scan_step;
    logic hit_capture;
    logic last_issue;
    logic move_write;
    logic drop;
    logic push_out;
  } dp_ctl_t;

  typedef struct packed {
    logic full;
    logic in_range;
    logic match;
    logic scan_done;
    logic hit_last;
    logic out_free;
  } dp_sts_t;

endpackage

/* src/drt_if.sv */
// valid/ready channel interfaces for command and result words
interface drt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  dev_type;
  logic [7:0]  dev_id;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [31:0] net_address;
  logic [5:0]  entry_index;

  modport source (output valid, command, dev_type, dev_id, pos_x, pos_y,
                  net_address, entry_index, input ready);
  modport sink (input valid, command, dev_type, dev_id, pos_x, pos_y,
                net_address, entry_index, output ready);
endinterface

interface drt_out_if;
  logic        valid;
  logic        ready;
  logic        done_ok;
  logic [6:0]  entry_count;
  logic [7:0]  out_type;
  logic [7:0]  out_id;
  logic [7:0]  out_x;
  logic [7:0]  out_y;
  logic [31:0] out_address;

  modport source (output valid, done_ok, entry_count, out_type, out_id, out_x, out_y,
                  out_address, input ready);
  modport sink (input valid, done_ok, entry_count, out_type, out_id, out_x, out_y,
                out_address, output ready);
endinterface

/* src/drt_ram.sv */
// generic simple dual-port ram with registered read
module drt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/drt_dp.sv */
// record table datapath: count, scan pointer, compare, result register
module drt_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  drt_pkg::dp_ctl_t    ctl,
  output drt_pkg::dp_sts_t    sts,
  input  drt_pkg::in_word_t   in_word,
  output drt_pkg::out_word_t  out_word,
  output logic                out_valid,
  input  logic                out_ready
);
  import drt_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;

  logic [CW-1:0] count_r;
  logic [CW-1:0] scan_r;
  logic          cmp_vld_r;
  logic [AW-1:0] cmp_idx_r;
  logic [AW-1:0] hit_idx_r;
  logic          ok_r;
  rec_t          rd_rec_r;
  in_word_t      key_r;
  out_word_t     out_r;
  logic          out_valid_r;

  logic          we;
  logic [AW-1:0] waddr;
  rec_t          wdata;
  logic [AW-1:0] raddr;
  rec_t          rdata;
  logic [RecW-1:0] rdata_raw;
  logic          key_hit;
  logic [CW-1:0] count_dec;

  assign count_dec = count_r - CW'(1);
  assign rdata     = rec_t'(rdata_raw);

  always_comb begin
    priority if (ctl.rd_issue) begin
      raddr = AW'(key_r.entry_index);
    end else if (ctl.last_issue) begin
      raddr = AW'(count_dec);
    end else begin
      raddr = AW'(scan_r);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = AW'(count_r);
    wdata = key_r.rec;
    if (ctl.add_exec && !sts.full) begin
      we = 1'b1;
    end else if (ctl.move_write) begin
      we    = 1'b1;
      waddr = hit_idx_r;
      wdata = rdata;
    end
  end

  drt_ram #(
    .WIDTH (RecW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign key_hit = (key_r.command == CMD_RM_ID) ?
                   (rdata.dev_id == key_r.rec.dev_id) :
                   (rdata.net_address == key_r.rec.net_address);

  assign sts.full      = (count_r == CW'(CAPACITY));
  assign sts.in_range  = (CMPW'(key_r.entry_index) < CMPW'(count_r));
  assign sts.match     = cmp_vld_r && key_hit;
  assign sts.scan_done = (scan_r == count_r) && !cmp_vld_r;
  assign sts.hit_last  = (hit_idx_r == AW'(count_dec));
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.add_exec && !sts.full) begin
        count_r <= count_r + CW'(1);
      end else if (ctl.drop) begin
        count_r <= count_dec;
      end
      if (ctl.load) begin
        cmp_vld_r <= 1'b0;
      end else if (ctl.scan_step) begin
        cmp_vld_r <= (scan_r < count_r);
      end
      if (ctl.push_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r    <= in_word;
      scan_r   <= '0;
      ok_r     <= 1'b0;
      rd_rec_r <= '0;
    end else begin
      if (ctl.scan_step && (scan_r < count_r)) begin
        scan_r    <= scan_r + CW'(1);
        cmp_idx_r <= AW'(scan_r);
      end
      if (ctl.add_exec) begin
        ok_r <= !sts.full;
      end
      if (ctl.rd_capture) begin
        ok_r     <= 1'b1;
        rd_rec_r <= rdata;
      end
      if (ctl.drop) begin
        ok_r <= 1'b1;
      end
    end
    if (ctl.hit_capture) begin
      hit_idx_r <= cmp_idx_r;
    end
    if (ctl.push_out) begin
      out_r.done_ok     <= ok_r;
      out_r.entry_count <= 7'(count_r);
      out_r.rec         <= rd_rec_r;
    end
  end

  assign out_word  = out_r;
  assign out_valid = out_valid_r;

endmodule

/* src/drt_ctrl.sv */
// record table controller state machine
module drt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  drt_pkg::cmd_t     in_cmd,
  output logic              in_ready,
  input  drt_pkg::dp_sts_t  sts,
  output drt_pkg::dp_ctl_t  ctl
);
  import drt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          unique case (in_cmd)
            CMD_ADD:     state_nxt = ST_ADD;
            CMD_READ:    state_nxt = ST_READ;
            CMD_RM_ID,
            CMD_RM_ADDR: state_nxt = ST_SCAN;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        ctl.add_exec = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_READ: begin
        if (sts.in_range) begin
          ctl.rd_issue = 1'b1;
          state_nxt    = ST_RWAIT;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_RWAIT: begin
        ctl.rd_capture = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_SCAN: begin
        priority if (sts.match) begin
          ctl.hit_capture = 1'b1;
          state_nxt       = ST_HIT;
        end else if (sts.scan_done) begin
          state_nxt = ST_DONE;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      ST_HIT: begin
        if (sts.hit_last) begin
          ctl.drop  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          ctl.last_issue = 1'b1;
          state_nxt      = ST_MOVE;
        end
      end
      ST_MOVE: begin
        ctl.move_write = 1'b1;
        ctl.drop       = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          ctl.push_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* src/device_record_table_core.sv */
// device record table top level
// usage:
//   in_chan carries one command word: add, remove by id, remove by address
//   or read at index; it is taken when valid and ready are both high.
//   out_chan returns exactly one result word per command: a success flag,
//   the record count after the command and, for a good read, the record.
// operation:
//   add writes the record into the next free slot; read checks the index
//   and, when it is in range, reads the record from the ram. remove scans
//   the stored records through the ram read port one per cycle until a
//   match or the end of the table; on a hit the last record is moved into
//   the freed slot, unless the hit is in the last slot itself.
//   one command is worked on at a time; ready is high only when idle.
// stalls:
//   the result sits in an output register, so the next command is accepted
//   while the receiver holds off; a command finishing while the previous
//   result is still waiting holds until that word is taken.
// reset:
//   synchronous active-low reset empties the table (count zero); record
//   storage itself is not cleared and no clearing pass is needed.
module device_record_table_core #(
  parameter int CAPACITY = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  drt_in_if.sink          in_chan,
  drt_out_if.source       out_chan
);
  import drt_pkg::*;

  dp_ctl_t   ctl;
  dp_sts_t   sts;
  in_word_t  in_word;
  out_word_t out_word;
  logic      out_valid;

  assign in_word.command             = cmd_t'(in_chan.command);
  assign in_word.rec.dev_type        = in_chan.dev_type;
  assign in_word.rec.dev_id          = in_chan.dev_id;
  assign in_word.rec.pos_x           = in_chan.pos_x;
  assign in_word.rec.pos_y           = in_chan.pos_y;
  assign in_word.rec.net_address     = in_chan.net_address;
  assign in_word.entry_index         = in_chan.entry_index;

  drt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_cmd   (in_word.command),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  drt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_word   (in_word),
    .out_word  (out_word),
    .out_valid (out_valid),
    .out_ready (out_chan.ready)
  );

  assign out_chan.valid       = out_valid;
  assign out_chan.done_ok     = out_word.done_ok;
  assign out_chan.entry_count = out_word.entry_count;
  assign out_chan.out_type    = out_word.rec.dev_type;
  assign out_chan.out_id      = out_word.rec.dev_id;
  assign out_chan.out_x       = out_word.rec.pos_x;
  assign out_chan.out_y       = out_word.rec.pos_y;
  assign out_chan.out_address = out_word.rec.net_address;

endmodule

/* verif/device_record_table_core_tb.sv */
// testbench for the device record table core: shadow table, random command mix
`timescale 1ns / 100ps

module device_record_table_core_tb;
  import drt_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int N_RANDOM = 1825;
  localparam int PAUSE_AT = 900;
  localparam int HOLD_AT_A = 300;
  localparam int HOLD_AT_B = 1200;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  class record_table_shadow;
    rec_t      slots[TABLE_DEPTH];
    int        count;
    out_word_t awaited[$];
    int        mismatches;

    function new();
      count = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void take_command(in_word_t w);
      out_word_t r;
      int        hit;
      int        i;
      r = '0;
      hit = -1;
      case (w.command)
        CMD_ADD: begin
          if (count < TABLE_DEPTH) begin
            slots[count] = w.rec;
            count++;
            r.done_ok = 1'b1;
          end
        end
        CMD_RM_ID, CMD_RM_ADDR: begin
          for (i = 0; i < count && hit < 0; i++) begin
            if (w.command == CMD_RM_ID && slots[i].dev_id == w.rec.dev_id)
              hit = i;
            if (w.command == CMD_RM_ADDR && slots[i].net_address == w.rec.net_address)
              hit = i;
          end
          if (hit >= 0) begin
            slots[hit] = slots[count - 1];
            count--;
            r.done_ok = 1'b1;
          end
        end
        CMD_READ: begin
          if (int'(w.entry_index) < count) begin
            r.rec = slots[w.entry_index];
            r.done_ok = 1'b1;
          end
        end
        default: ;
      endcase
      r.entry_count = 7'(count);
      awaited.push_back(r);
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch %s: expected %0h got %0h", what, want, got);
    endfunction

    function void check_reply(out_word_t got);
      out_word_t want;
      if (awaited.size() == 0) begin
        report("unexpected word, count", '0, 32'(got.entry_count));
        return;
      end
      want = awaited.pop_front();
      if (want.done_ok !== got.done_ok)
        report("done_ok", 32'(want.done_ok), 32'(got.done_ok));
      if (want.entry_count !== got.entry_count)
        report("entry_count", 32'(want.entry_count), 32'(got.entry_count));
      if (want.rec.dev_type !== got.rec.dev_type)
        report("out_type", 32'(want.rec.dev_type), 32'(got.rec.dev_type));
      if (want.rec.dev_id !== got.rec.dev_id)
        report("out_id", 32'(want.rec.dev_id), 32'(got.rec.dev_id));
      if (want.rec.pos_x !== got.rec.pos_x)
        report("out_x", 32'(want.rec.pos_x), 32'(got.rec.pos_x));
      if (want.rec.pos_y !== got.rec.pos_y)
        report("out_y", 32'(want.rec.pos_y), 32'(got.rec.pos_y));
      if (want.rec.net_address !== got.rec.net_address)
        report("out_address", want.rec.net_address, got.rec.net_address);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   sender_steady;
  int   idle_cycles = 0;

  record_table_shadow shadow = new();

  drt_in_if  in_if();
  drt_out_if out_if();

  device_record_table_core #(
    .CAPACITY(TABLE_DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if.sink),
    .out_chan(out_if.source)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int unsigned next_gap();
    return sender_steady ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic in_word_t noise_word();
    in_word_t w;
    w.command = cmd_t'(2'($urandom_range(0, 3)));
    w.rec.dev_type = 8'($urandom);
    w.rec.dev_id = 8'($urandom);
    w.rec.pos_x = 8'($urandom);
    w.rec.pos_y = 8'($urandom);
    w.rec.net_address = $urandom;
    w.entry_index = 6'($urandom);
    return w;
  endfunction

  function automatic in_word_t cmd_word(cmd_t c, logic [7:0] ty, logic [7:0] id,
                                        logic [7:0] px, logic [7:0] py,
                                        logic [31:0] addr, logic [5:0] idx);
    in_word_t w;
    w.command = c;
    w.rec.dev_type = ty;
    w.rec.dev_id = id;
    w.rec.pos_x = px;
    w.rec.pos_y = py;
    w.rec.net_address = addr;
    w.entry_index = idx;
    return w;
  endfunction

  function automatic in_word_t shaped_word(int unsigned mode);
    in_word_t    w;
    int unsigned roll;
    int unsigned add_pct;
    int unsigned rm_pct;
    int unsigned slot;
    w = noise_word();
    roll = $urandom_range(0, 99);
    case (mode)
      0: begin
        add_pct = 70;
        rm_pct = 15;
      end
      1: begin
        add_pct = 15;
        rm_pct = 65;
      end
      default: begin
        add_pct = 30;
        rm_pct = 35;
      end
    endcase
    if (roll < add_pct) begin
      w.command = CMD_ADD;
      if ($urandom_range(0, 9) < 3) w.rec.dev_id = 8'($urandom_range(0, 7));
      if ($urandom_range(0, 9) < 3)
        w.rec.net_address = $urandom_range(0, 1) ? $urandom_range(0, 7)
                                                 : (32'hFFFF_FFF8 | $urandom_range(0, 7));
    end else if (roll < add_pct + rm_pct) begin
      w.command = $urandom_range(0, 1) ? CMD_RM_ID : CMD_RM_ADDR;
      if (shadow.count > 0 && $urandom_range(0, 9) < 8) begin
        slot = $urandom_range(0, shadow.count - 1);
        w.rec.dev_id = shadow.slots[slot].dev_id;
        w.rec.net_address = shadow.slots[slot].net_address;
      end
    end else begin
      w.command = CMD_READ;
      if (shadow.count > 0 && $urandom_range(0, 3) != 0)
        w.entry_index = 6'($urandom_range(0, shadow.count - 1));
    end
    return w;
  endfunction

  task automatic issue_cmd(input in_word_t w, input int unsigned gap);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.command <= w.command;
    in_if.dev_type <= w.rec.dev_type;
    in_if.dev_id <= w.rec.dev_id;
    in_if.pos_x <= w.rec.pos_x;
    in_if.pos_y <= w.rec.pos_y;
    in_if.net_address <= w.rec.net_address;
    in_if.entry_index <= w.entry_index;
    in_if.valid <= 1'b1;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    shadow.take_command(w);
  endtask

  initial begin : stimulus
    int unsigned mode;
    int unsigned phase_left;
    int unsigned n;
    rst_n = 1'b0;
    sender_steady = 1'b0;
    in_if.valid = 1'b0;
    in_if.command = CMD_ADD;
    in_if.dev_type = '0;
    in_if.dev_id = '0;
    in_if.pos_x = '0;
    in_if.pos_y = '0;
    in_if.net_address = '0;
    in_if.entry_index = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // empty table
    issue_cmd(cmd_word(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 6'd0), next_gap());
    issue_cmd(cmd_word(CMD_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 6'd63),
              next_gap());
    issue_cmd(cmd_word(CMD_RM_ID, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 6'd0), next_gap());
    issue_cmd(cmd_word(CMD_RM_ADDR, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 6'd0), next_gap());
    // field extremes
    issue_cmd(cmd_word(CMD_ADD, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 6'd0), next_gap());
    issue_cmd(cmd_word(CMD_ADD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 6'd63),
              next_gap());
    issue_cmd(cmd_word(CMD_ADD, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 32'h1234_5678, 6'd21),
              next_gap());
    issue_cmd(cmd_word(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 6'd0), next_gap());
    issue_cmd(cmd_word(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 6'd1), next_gap());
    issue_cmd(cmd_word(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 6'd2), next_gap());
    issue_cmd(cmd_word(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 6'd3), next_gap());
    // no match
    issue_cmd(cmd_word(CMD_RM_ID, 8'h00, 8'h77, 8'h00, 8'h00, 32'h0, 6'd0), next_gap());
    issue_cmd(cmd_word(CMD_RM_ADDR, 8'h00, 8'h00, 8'h00, 8'h00, 32'hDEAD_BEEF, 6'd0),
              next_gap());
    // middle hit pulls the last record down
    issue_cmd(cmd_word(CMD_RM_ID, 8'h00, 8'hFF, 8'h00, 8'h00, 32'h0, 6'd0), next_gap());
    issue_cmd(cmd_word(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 6'd1), next_gap());
    // hit in last slot
    issue_cmd(cmd_word(CMD_RM_ADDR, 8'h00, 8'h00, 8'h00, 8'h00, 32'h1234_5678, 6'd0),
              next_gap());
    // duplicate ids, first match wins
    issue_cmd(cmd_word(CMD_ADD, 8'h11, 8'h33, 8'h01, 8'h02, 32'h0000_0001, 6'd0),
              next_gap());
    issue_cmd(cmd_word(CMD_ADD, 8'h22, 8'h33, 8'h03, 8'h04, 32'h0000_0002, 6'd0),
              next_gap());
    issue_cmd(cmd_word(CMD_RM_ID, 8'h00, 8'h33, 8'h00, 8'h00, 32'h0, 6'd0), next_gap());
    issue_cmd(cmd_word(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 6'd1), next_gap());
    issue_cmd(cmd_word(CMD_RM_ADDR, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 6'd0), next_gap());
    issue_cmd(cmd_word(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 6'd0), next_gap());
    issue_cmd(cmd_word(CMD_RM_ID, 8'h00, 8'h33, 8'h00, 8'h00, 32'h0, 6'd0), next_gap());
    issue_cmd(cmd_word(CMD_READ, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 6'd0), next_gap());

    n = 0;
    phase_left = 0;
    mode = 0;
    while (n < N_RANDOM) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(100, 250);
        mode = (n == 0) ? 0 : $urandom_range(0, 2);
        sender_steady = ($urandom_range(0, 3) == 0);
      end
      if (n == PAUSE_AT) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (shadow.pending() != 0) @(negedge clk);
      end
      issue_cmd(shaped_word(mode), next_gap());
      n++;
      phase_left--;
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (shadow.mismatches == 0 && shadow.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin : result_sink
    int unsigned taken;
    int unsigned gap;
    bit          steady;
    out_word_t   got;
    taken = 0;
    steady = 1'b0;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      if (taken == HOLD_AT_A || taken == HOLD_AT_B) gap = HOLD_CYCLES;
      else if (steady) gap = 0;
      else gap = $urandom_range(0, 15);
      @(negedge clk);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      got.done_ok = out_if.done_ok;
      got.entry_count = out_if.entry_count;
      got.rec.dev_type = out_if.out_type;
      got.rec.dev_id = out_if.out_id;
      got.rec.pos_x = out_if.out_x;
      got.rec.pos_y = out_if.out_y;
      got.rec.net_address = out_if.out_address;
      shadow.check_reply(got);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
